### hdl/hcd_pkg.sv
// Package: shared types, register indexes and the sequencer state set of the comb detector.
`default_nettype none
package hcd_pkg;
    localparam int RatioW = 24;
    localparam int BinW = 15;
    localparam int NumRegs = 8;

    localparam logic [2:0] RegPeakCount = 3'd0;
    localparam logic [2:0] RegSuppress = 3'd1;
    localparam logic [2:0] RegTolerance = 3'd2;
    localparam logic [2:0] RegMaxF0 = 3'd3;
    localparam logic [2:0] RegMaxHarm = 3'd4;
    localparam logic [2:0] RegMinMembers = 3'd5;
    localparam logic [2:0] RegScoreThr = 3'd6;
    localparam logic [2:0] RegLineThr = 3'd7;

    typedef struct packed {
        logic [3:0] peak_count;
        logic [2:0] suppress_radius;
        logic [1:0] harmonic_tolerance;
        logic [9:0] max_f0_bin;
        logic [3:0] max_harmonic;
        logic [3:0] min_members;
        logic [23:0] score_threshold;
        logic [23:0] line_threshold;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_SCAN_END,
        ST_MARK,
        ST_BASE,
        ST_HARM,
        ST_MATCH,
        ST_DIV,
        ST_CAND,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       found;
        logic [3:0] members;
        logic [23:0] score;
        logic [9:0] f0;
        logic [3:0] peaks;
        logic [14:0] lines;
        logic       ovf;
    } result_t;
endpackage
`default_nettype wire

### hdl/hcd_cfg_regs.sv
// Configuration register file of the comb detector.
`default_nettype none
module hcd_cfg_regs
    import hcd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [23:0] cfg_wdata,
    output cfg_t             cfg
);
    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.peak_count <= 4'd15;
            cfg_reg.suppress_radius <= 3'd3;
            cfg_reg.harmonic_tolerance <= 2'd1;
            cfg_reg.max_f0_bin <= 10'd128;
            cfg_reg.max_harmonic <= 4'd8;
            cfg_reg.min_members <= 4'd3;
            cfg_reg.score_threshold <= 24'd24576;
            cfg_reg.line_threshold <= 24'd40960;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                RegPeakCount: cfg_reg.peak_count <= cfg_wdata[3:0];
                RegSuppress: cfg_reg.suppress_radius <= cfg_wdata[2:0];
                RegTolerance: cfg_reg.harmonic_tolerance <= cfg_wdata[1:0];
                RegMaxF0: cfg_reg.max_f0_bin <= cfg_wdata[9:0];
                RegMaxHarm: cfg_reg.max_harmonic <= cfg_wdata[3:0];
                RegMinMembers: cfg_reg.min_members <= cfg_wdata[3:0];
                RegScoreThr: cfg_reg.score_threshold <= cfg_wdata;
                RegLineThr: cfg_reg.line_threshold <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;
endmodule
`default_nettype wire

### hdl/hcd_divider.sv
// Iterative restoring divider for the mean of up to fifteen 24-bit ratios.
`default_nettype none
module hcd_divider
    import hcd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [27:0] dividend,
    input  wire logic [3:0]  divisor,
    output logic             busy,
    output logic [23:0]      quotient
);
    logic [27:0] quo_reg;
    logic [3:0]  rem_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [3:0]  div_reg;
    logic [4:0]  trial;

    assign trial = {rem_reg, quo_reg[27]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg <= 5'd27;
        end else if (busy_reg) begin
            if (cnt_reg == 5'd0) busy_reg <= 1'b0;
            cnt_reg <= cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                rem_reg <= 4'(trial - {1'b0, div_reg});
                quo_reg <= {quo_reg[26:0], 1'b1};
            end else begin
                rem_reg <= trial[3:0];
                quo_reg <= {quo_reg[26:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign quotient = quo_reg[23:0];
endmodule
`default_nettype wire

### hdl/harmonic_comb_detector_unit.sv
// Top level of the harmonic comb detector: bin store, peak picker and comb search sequencer.
//
// Usage: spectrum bins stream in on the s_axis channel from bin 0, one transfer per bin,
// with the last bin flagged by s_axis_tlast. Bins below the end are taken back to back.
// On the last bin the block stops taking transfers and runs its sequencer: a pass over
// the taken-mark memory to clear it, then up to peak_count scans of the bin store, with
// up to 2*suppress_radius+1 bins marked around each pick. The comb search then visits,
// per base bin, a base step, a step for each harmonic tried and one per listed peak
// checked, the divider that forms the mean (skipped when nothing matched) and a step to
// update the best candidate. One result transfer follows on m_axis and is held until
// m_axis_tready is high; no new bin is accepted until it has gone. The store read port
// is the one shared resource that sets the scan length. Configuration writes go straight
// into registers and are meant for idle periods only. Reset (aresetn low, synchronous)
// clears the bin and line counters, the overflow flag, the peak count and the sequencer;
// the bin store itself is not cleared, as only bins of the current spectrum are ever read.
`default_nettype none
module harmonic_comb_detector_unit
    import hcd_pkg::*;
#(
    parameter int SEGMENT_LENGTH = 32768,
    parameter int MAX_PEAKS = 15
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // y2_ratio[23:0], y4_ratio[47:24]
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // comb_found[0], members[4:1], mean_ratio[28:5], f0_bin[38:29], peaks_found[42:39],
    // line_count[57:43], overflow[58], zero fill up to 63
    output logic [63:0]      m_axis_tdata,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [23:0] cfg_wdata
);
    localparam int Depth = SEGMENT_LENGTH / 2;
    localparam int AW = $clog2(Depth);
    localparam int CW = $clog2(Depth + 3);
    localparam int TW = CW + 5;
    localparam int PW = $clog2(MAX_PEAKS + 1);
    localparam int PIW = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;

    cfg_t cfg;
    hcd_cfg_regs u_cfg (
        .aclk, .aresetn, .cfg_wr_en, .cfg_addr, .cfg_wdata, .cfg
    );

    // Memories
    logic [23:0] store_mem [Depth];
    logic        mark_mem [Depth];
    logic [CW-1:0] peak_bin_mem [MAX_PEAKS];
    logic [23:0] peak_val_mem [MAX_PEAKS];

    state_t state_reg, state_next;
    logic [CW-1:0] bin_reg;
    logic [14:0]   lines_reg;
    logic          ovf_reg;
    logic [CW-1:0] top_reg;
    logic [CW-1:0] idx_reg;
    logic          rd_vld_reg;
    logic [CW-1:0] rd_bin_reg;
    logic [23:0]   st_q_reg;
    logic          mk_q_reg;
    logic [23:0]   best_v_reg;
    logic [CW-1:0] best_i_reg;
    logic [CW-1:0] mark_hi_reg;
    logic [PW-1:0] got_reg;
    logic [PW-1:0] want;
    logic [9:0]    b0_reg;
    logic [4:0]    m_reg;
    logic [TW-1:0] tgt_reg;
    logic [TW-1:0] lo_reg, hi_reg;
    logic [PIW-1:0] pi_reg;
    logic [27:0]   tot_reg;
    logic [3:0]    n_reg;
    logic [3:0]    bn_reg;
    logic [23:0]   bs_reg;
    logic [9:0]    bb_reg;
    result_t       res_reg;

    logic [23:0] v_in;
    logic        in_fire, out_fire;
    logic        div_start, div_busy;
    logic [23:0] div_q;
    logic [CW-1:0] pk_bin;
    logic [23:0]   pk_val;

    assign v_in = (s_axis_tdata[23:0] > s_axis_tdata[47:24]) ?
                  s_axis_tdata[23:0] : s_axis_tdata[47:24];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign want = (int'(cfg.peak_count) > MAX_PEAKS) ? PW'(MAX_PEAKS) : PW'(cfg.peak_count);
    assign pk_bin = peak_bin_mem[pi_reg];
    assign pk_val = peak_val_mem[pi_reg];

    // Bin store write port and shared read port.
    always_ff @(posedge aclk) begin
        if (in_fire && bin_reg >= CW'(2) && bin_reg < CW'(Depth + 2))
            store_mem[AW'(bin_reg - CW'(2))] <= v_in;
        st_q_reg <= store_mem[AW'(idx_reg - CW'(2))];
    end

    // Taken marks: cleared by a pass, set around each pick.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR)
            mark_mem[AW'(idx_reg - CW'(2))] <= 1'b0;
        else if (state_reg == ST_MARK)
            mark_mem[AW'(idx_reg - CW'(2))] <= 1'b1;
        mk_q_reg <= mark_mem[AW'(idx_reg - CW'(2))];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SCAN_END && best_v_reg != '0) begin
            peak_bin_mem[got_reg[PIW-1:0]] <= best_i_reg;
            peak_val_mem[got_reg[PIW-1:0]] <= best_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_fire && s_axis_tlast) state_next = ST_CLEAR;
            ST_CLEAR: if (idx_reg >= top_reg) state_next = ST_SCAN;
            ST_SCAN: begin
                if (top_reg < CW'(2) || got_reg >= want) state_next = ST_BASE;
                else if (idx_reg > top_reg && !rd_vld_reg) state_next = ST_SCAN_END;
            end
            ST_SCAN_END: state_next = (best_v_reg == '0) ? ST_BASE : ST_MARK;
            ST_MARK: if (idx_reg >= mark_hi_reg) state_next = ST_SCAN;
            // The base counter wraps at 1023, so stop on the wrap as well.
            ST_BASE: state_next = (b0_reg > cfg.max_f0_bin || b0_reg == 10'd0 ||
                                   top_reg < CW'(2)) ? ST_OUT : ST_HARM;
            ST_HARM: state_next = (m_reg > {1'b0, cfg.max_harmonic} ||
                                   tgt_reg > TW'(top_reg)) ? ST_DIV : ST_MATCH;
            ST_MATCH: begin
                if (got_reg == '0 || PW'(pi_reg) >= got_reg) state_next = ST_HARM;
                else if (TW'(pk_bin) >= lo_reg && TW'(pk_bin) <= hi_reg)
                    state_next = ST_HARM;
                else if (PW'(pi_reg) + PW'(1) >= got_reg) state_next = ST_HARM;
            end
            ST_DIV: if (!div_start && !div_busy) state_next = ST_CAND;
            ST_CAND: state_next = ST_BASE;
            ST_OUT: if (out_fire) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    logic div_go_reg;
    assign div_start = (state_reg == ST_DIV) && !div_go_reg && n_reg != '0;

    hcd_divider u_div (
        .aclk, .aresetn, .start(div_start), .dividend(tot_reg), .divisor(n_reg),
        .busy(div_busy), .quotient(div_q)
    );

    logic [TW-1:0] tgt_new;
    logic [23:0]   mean;
    assign tgt_new = tgt_reg + TW'(b0_reg);
    assign mean = (n_reg == '0) ? 24'd0 : div_q;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_reg <= '0;
            lines_reg <= '0;
            ovf_reg <= 1'b0;
            got_reg <= '0;
            rd_vld_reg <= 1'b0;
            div_go_reg <= 1'b0;
        end else begin
            div_go_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        if (bin_reg >= CW'(2)) begin
                            if (bin_reg < CW'(Depth + 2)) begin
                                if (v_in >= cfg.line_threshold)
                                    lines_reg <= lines_reg + 15'd1;
                            end else ovf_reg <= 1'b1;
                        end
                        if (bin_reg < CW'(Depth + 2)) bin_reg <= bin_reg + CW'(1);
                        top_reg <= (bin_reg > CW'(Depth + 1)) ? CW'(Depth + 1) : bin_reg;
                        idx_reg <= CW'(2);
                        got_reg <= '0;
                    end
                end
                ST_CLEAR: begin
                    idx_reg <= idx_reg + CW'(1);
                    if (idx_reg >= top_reg) begin
                        idx_reg <= CW'(2);
                        rd_vld_reg <= 1'b0;
                        best_v_reg <= '0;
                        best_i_reg <= '0;
                    end
                end
                ST_SCAN: begin
                    // One address issued per cycle; compare the previous read.
                    rd_vld_reg <= (idx_reg <= top_reg);
                    rd_bin_reg <= idx_reg;
                    if (idx_reg <= top_reg) idx_reg <= idx_reg + CW'(1);
                    if (rd_vld_reg && !mk_q_reg && st_q_reg > best_v_reg) begin
                        best_v_reg <= st_q_reg;
                        best_i_reg <= rd_bin_reg;
                    end
                    b0_reg <= 10'd2;
                    bn_reg <= '0;
                    bs_reg <= '0;
                    bb_reg <= '0;
                end
                ST_SCAN_END: begin
                    idx_reg <= (best_i_reg >= CW'(2) + CW'(cfg.suppress_radius)) ?
                               best_i_reg - CW'(cfg.suppress_radius) : CW'(2);
                    mark_hi_reg <= (best_i_reg + CW'(cfg.suppress_radius) > top_reg) ?
                                   top_reg : best_i_reg + CW'(cfg.suppress_radius);
                    if (best_v_reg != '0) got_reg <= got_reg + PW'(1);
                end
                ST_MARK: begin
                    idx_reg <= idx_reg + CW'(1);
                    if (idx_reg >= mark_hi_reg) begin
                        idx_reg <= CW'(2);
                        rd_vld_reg <= 1'b0;
                        best_v_reg <= '0;
                        best_i_reg <= '0;
                    end
                end
                ST_BASE: begin
                    m_reg <= 5'd1;
                    tgt_reg <= TW'(b0_reg);
                    tot_reg <= '0;
                    n_reg <= '0;
                    pi_reg <= '0;
                    lo_reg <= (TW'(b0_reg) >= TW'(2) + TW'(cfg.harmonic_tolerance))
                              ? TW'(b0_reg) - TW'(cfg.harmonic_tolerance)
                              : TW'(2);
                    hi_reg <= (TW'(b0_reg) + TW'(cfg.harmonic_tolerance)
                               > TW'(top_reg)) ? TW'(top_reg)
                              : TW'(b0_reg) + TW'(cfg.harmonic_tolerance);
                end
                ST_HARM: pi_reg <= '0;
                ST_MATCH: begin
                    if (got_reg == '0 || PW'(pi_reg) >= got_reg) begin
                        m_reg <= m_reg + 5'd1;
                    end else if (TW'(pk_bin) >= lo_reg && TW'(pk_bin) <= hi_reg)
                    begin
                        tot_reg <= tot_reg + 28'(pk_val);
                        n_reg <= n_reg + 4'd1;
                        m_reg <= m_reg + 5'd1;
                    end else if (PW'(pi_reg) + PW'(1) >= got_reg) begin
                        m_reg <= m_reg + 5'd1;
                    end else begin
                        pi_reg <= pi_reg + PIW'(1);
                    end
                    if (state_next == ST_HARM) begin
                        tgt_reg <= tgt_new;
                        lo_reg <= (tgt_new >= TW'(2) + TW'(cfg.harmonic_tolerance))
                                  ? tgt_new - TW'(cfg.harmonic_tolerance) : TW'(2);
                        hi_reg <= (tgt_new + TW'(cfg.harmonic_tolerance)
                                   > TW'(top_reg)) ? TW'(top_reg)
                                  : tgt_new + TW'(cfg.harmonic_tolerance);
                    end
                end
                // Held high for the whole division so that it starts only once.
                ST_DIV: div_go_reg <= 1'b1;
                ST_CAND: begin
                    if (n_reg >= cfg.min_members &&
                        (n_reg > bn_reg || (n_reg == bn_reg && mean > bs_reg))) begin
                        bn_reg <= n_reg;
                        bs_reg <= mean;
                        bb_reg <= b0_reg;
                    end
                    b0_reg <= b0_reg + 10'd1;
                end
                ST_OUT: begin
                    if (out_fire) begin
                        bin_reg <= '0;
                        lines_reg <= '0;
                        ovf_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    logic found;
    assign found = bn_reg >= cfg.min_members && bs_reg >= cfg.score_threshold;

    always_ff @(posedge aclk) begin
        if (state_reg != ST_OUT) begin
            res_reg.found <= found;
            res_reg.members <= found ? bn_reg : 4'd0;
            res_reg.score <= bs_reg;
            res_reg.f0 <= bb_reg;
            res_reg.peaks <= 4'(got_reg);
            res_reg.lines <= lines_reg;
            res_reg.ovf <= ovf_reg;
        end
    end

    assign m_axis_tdata = {5'd0, res_reg.ovf, res_reg.lines, res_reg.peaks, res_reg.f0,
                           res_reg.score, res_reg.members, res_reg.found};

    no_input_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    peaks_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        got_reg <= PW'(MAX_PEAKS)) else $error("too many peaks");
    result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
endmodule
`default_nettype wire
